FILE: rtl/cdf_pkg.sv
package cdf_pkg;

  typedef enum logic [2:0] {
    KIND_FILL     = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_MISMATCH = 3'd3,
    KIND_END      = 3'd4,
    KIND_AFTER    = 3'd5
  } kind_t;

  localparam logic [47:0] FILL_UPPER     = 48'h5555_5555_5555;
  localparam logic [3:0]  BYTES_PER_WORD = 4'd8;

endpackage

FILE: rtl/capture_record_deframer.sv
// Each input word passes the input register, then the result register; the record
// state is updated between the two.
// Throughput: one word per cycle, sustained while out_ready stays high.
// Synchronous active-high rst clears both valid flags, the record state and the
// record counter; payload registers are not reset.
module capture_record_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] stream_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  word_kind,
  output logic [63:0] data_word,
  output logic [15:0] record_length,
  output logic [2:0]  pad_bytes,
  output logic [3:0]  valid_bytes,
  output logic        last_of_record,
  output logic [31:0] record_total
);

  // input stage
  logic        s1_valid;
  logic [63:0] s1_word;
  logic        s2_ready;
  logic        adv;

  // record state
  logic        in_payload,      in_payload_next;
  logic [13:0] words_remaining, words_remaining_next;
  logic [2:0]  tail_pad,        tail_pad_next;
  logic [15:0] current_length,  current_length_next;
  logic        stream_ended,    stream_ended_next;
  logic [31:0] record_counter,  record_counter_next;

  // result
  cdf_pkg::kind_t kind_next;
  logic [63:0]    data_next;
  logic [15:0]    rlen_next;
  logic [2:0]     pad_next;
  logic [3:0]     valid_next;
  logic           last_next;

  logic [15:0]    hdr_len;
  logic [2:0]     hdr_pad;
  logic [13:0]    hdr_words;

  assign s2_ready = !out_valid || out_ready;
  assign adv      = s1_valid && s2_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_word <= stream_word;
    end
  end

  assign hdr_len   = s1_word[15:0];
  assign hdr_pad   = 3'(~hdr_len[2:0] + 3'd1);
  assign hdr_words = 14'(hdr_len[15:3]) + {13'd0, (hdr_len[2:0] != 3'd0)};

  always_comb begin
    in_payload_next      = in_payload;
    words_remaining_next = words_remaining;
    tail_pad_next        = tail_pad;
    current_length_next  = current_length;
    stream_ended_next    = stream_ended;
    record_counter_next  = record_counter;
    kind_next            = cdf_pkg::KIND_FILL;
    data_next            = 64'd0;
    rlen_next            = 16'd0;
    pad_next             = 3'd0;
    valid_next           = 4'd0;
    last_next            = 1'b0;

    if (stream_ended) begin
      kind_next = cdf_pkg::KIND_AFTER;
    end else if (in_payload) begin
      kind_next = cdf_pkg::KIND_PAYLOAD;
      data_next = s1_word;
      rlen_next = current_length;
      pad_next  = tail_pad;
      if (words_remaining <= 14'd1) begin
        last_next            = 1'b1;
        valid_next           = cdf_pkg::BYTES_PER_WORD - {1'b0, tail_pad};
        in_payload_next      = 1'b0;
        words_remaining_next = 14'd0;
        record_counter_next  = record_counter + 32'd1;
      end else begin
        valid_next           = cdf_pkg::BYTES_PER_WORD;
        words_remaining_next = words_remaining - 14'd1;
      end
    end else if (s1_word[63:16] == cdf_pkg::FILL_UPPER) begin
      kind_next = cdf_pkg::KIND_FILL;
    end else if (s1_word[63:48] != 16'd0) begin
      kind_next = cdf_pkg::KIND_MISMATCH;
    end else if (hdr_len == 16'd0) begin
      kind_next           = cdf_pkg::KIND_END;
      stream_ended_next   = 1'b1;
      current_length_next = 16'd0;
    end else begin
      kind_next            = cdf_pkg::KIND_HEADER;
      current_length_next  = hdr_len;
      words_remaining_next = hdr_words;
      tail_pad_next        = hdr_pad;
      in_payload_next      = 1'b1;
      rlen_next            = hdr_len;
      pad_next             = hdr_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      words_remaining <= 14'd0;
      tail_pad        <= 3'd0;
      current_length  <= 16'd0;
      stream_ended    <= 1'b0;
      record_counter  <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      if (adv) begin
        in_payload      <= in_payload_next;
        words_remaining <= words_remaining_next;
        tail_pad        <= tail_pad_next;
        current_length  <= current_length_next;
        stream_ended    <= stream_ended_next;
        record_counter  <= record_counter_next;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
    if (adv) begin
      word_kind      <= kind_next;
      data_word      <= data_next;
      record_length  <= rlen_next;
      pad_bytes      <= pad_next;
      valid_bytes    <= valid_next;
      last_of_record <= last_next;
      record_total   <= record_counter_next;
    end
  end

  a_end_no_payload: assert property (@(posedge clk) disable iff (rst)
    stream_ended |-> !in_payload)
    else $error("payload state active after end marker");

  a_payload_words: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> words_remaining != 14'd0)
    else $error("in record with no words left");

  a_non_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && word_kind != cdf_pkg::KIND_PAYLOAD) |->
      (valid_bytes == 4'd0 && !last_of_record && data_word == 64'd0))
    else $error("non-payload result carries payload fields");

endmodule

FILE: bench/tb_capture_record_deframer.sv
module tb_capture_record_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cdf_pkg::kind_t kind;
    logic [63:0]    data;
    logic [15:0]    length;
    logic [2:0]     pad;
    logic [3:0]     valid;
    logic           last;
    logic [31:0]    total;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] stream_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  word_kind;
  logic [63:0] data_word;
  logic [15:0] record_length;
  logic [2:0]  pad_bytes;
  logic [3:0]  valid_bytes;
  logic        last_of_record;
  logic [31:0] record_total;

  capture_record_deframer DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_word    (stream_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .word_kind      (word_kind),
    .data_word      (data_word),
    .record_length  (record_length),
    .pad_bytes      (pad_bytes),
    .valid_bytes    (valid_bytes),
    .last_of_record (last_of_record),
    .record_total   (record_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [63:0]     capture_words[$];
  deframe_result_t predicted_results[$];
  int              mismatches = 0;
  int              in_hold = 0;
  int              out_hold = 0;
  int              in_calm = 0;
  int              out_calm = 0;

  // deframer state as the predictor tracks it
  logic        in_record = 1'b0;
  logic [13:0] words_left = '0;
  logic [2:0]  tail_pad = '0;
  logic [15:0] record_len = '0;
  logic        ended = 1'b0;
  logic [31:0] records_done = '0;

  function automatic deframe_result_t deframe_word(logic [63:0] w);
    deframe_result_t r;
    logic [15:0] len;
    r = '{cdf_pkg::KIND_FILL, '0, '0, '0, '0, 1'b0, '0};
    len = w[15:0];
    if (ended) begin
      r.kind = cdf_pkg::KIND_AFTER;
    end else if (in_record) begin
      r.kind = cdf_pkg::KIND_PAYLOAD;
      r.data = w;
      r.length = record_len;
      r.pad = tail_pad;
      if (words_left <= 14'd1) begin
        r.last = 1'b1;
        r.valid = cdf_pkg::BYTES_PER_WORD - {1'b0, tail_pad};
        in_record = 1'b0;
        words_left = '0;
        records_done = records_done + 32'd1;
      end else begin
        r.valid = cdf_pkg::BYTES_PER_WORD;
        words_left = words_left - 14'd1;
      end
    end else if (w[63:16] == cdf_pkg::FILL_UPPER) begin
      r.kind = cdf_pkg::KIND_FILL;
    end else if (w[63:48] != 16'd0) begin
      r.kind = cdf_pkg::KIND_MISMATCH;
    end else if (len == 16'd0) begin
      r.kind = cdf_pkg::KIND_END;
      ended = 1'b1;
      record_len = '0;
    end else begin
      r.kind = cdf_pkg::KIND_HEADER;
      record_len = len;
      words_left = 14'((17'(len) + 17'd7) >> 3);
      tail_pad = 3'(4'd8 - {1'b0, len[2:0]});
      in_record = 1'b1;
      r.length = len;
      r.pad = tail_pad;
    end
    r.total = records_done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // random idle draw, with occasional runs of back-to-back transactions
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] header_word(logic [15:0] len);
    return {16'h0000, $urandom, len};
  endfunction

  task automatic push_record(int unsigned len);
    int unsigned n;
    int unsigned pick;
    capture_words.push_back(header_word(16'(len)));
    n = (len + 7) / 8;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) capture_words.push_back({cdf_pkg::FILL_UPPER, 16'($urandom)});
      else if (pick < 14) capture_words.push_back({16'h0000, 48'(rand64())});
      else capture_words.push_back(rand64());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_hold <= 0;
    end else begin
      if (in_valid && in_ready) predicted_results.push_back(deframe_word(stream_word));
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold <= in_hold - 1;
        end else if (capture_words.size() > 0) begin
          stream_word <= capture_words.pop_front();
          in_valid <= 1'b1;
          in_hold <= draw_wait(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t want;
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      w = out_hold;
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected transaction: word_kind 0x%0h", word_kind);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("word_kind", 64'(want.kind), 64'(word_kind));
          check_field("data_word", want.data, data_word);
          check_field("record_length", 64'(want.length), 64'(record_length));
          check_field("pad_bytes", 64'(want.pad), 64'(pad_bytes));
          check_field("valid_bytes", 64'(want.valid), 64'(valid_bytes));
          check_field("last_of_record", 64'(want.last), 64'(last_of_record));
          check_field("record_total", 64'(want.total), 64'(record_total));
        end
        w = draw_wait(out_calm);
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        out_hold <= w - 1;
      end else begin
        out_ready <= 1'b1;
        out_hold <= 0;
      end
    end
  end

  initial begin
    int unsigned pick;

    // fill, mismatch and near-miss words while hunting
    capture_words.push_back(64'h5555_5555_5555_5555);
    capture_words.push_back({cdf_pkg::FILL_UPPER, 16'hFFFF});
    capture_words.push_back({cdf_pkg::FILL_UPPER, 16'h0000});
    capture_words.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    capture_words.push_back(64'h0001_0000_0000_0000);
    capture_words.push_back(64'h5555_5555_5554_FFFF);
    // records whose payload looks like fill, an end marker or a header
    capture_words.push_back(64'h0000_FFFF_FFFF_0001);
    capture_words.push_back(64'h5555_5555_5555_5555);
    capture_words.push_back(64'h0000_0000_0000_0008);
    capture_words.push_back(64'h0000_0000_0000_0000);
    capture_words.push_back(64'h0000_0000_0000_0009);
    capture_words.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    capture_words.push_back(64'h0000_0000_0000_0010);
    push_record(16);
    push_record(15);
    push_record(7);

    while (capture_words.size() < 870) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 4) != 0) push_record($urandom_range(1, 64));
        else push_record($urandom_range(65, 2000));
      end else if (pick < 85) begin
        capture_words.push_back({cdf_pkg::FILL_UPPER, 16'($urandom)});
      end else if (pick < 95) begin
        capture_words.push_back({16'($urandom_range(1, 65535)), 48'(rand64())});
      end else begin
        capture_words.push_back(rand64() | 64'h1);
      end
    end
    push_record(2041);

    capture_words.push_back({16'h0000, $urandom, 16'h0000});
    capture_words.push_back(64'h0000_0000_0000_0000);
    capture_words.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    capture_words.push_back(64'h5555_5555_5555_5555);
    capture_words.push_back(header_word(16'd5));
    repeat (10) capture_words.push_back(rand64());

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (capture_words.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
